// ----- rtl/bmrc_pkg.sv -----
// Package for the boot module range checker.
// Holds sizes, status and register codes and the controller/datapath structs.
// No dependencies.
package bmrc_pkg;

  localparam int MAX_MODULES = 16;
  localparam int IDX_W       = (MAX_MODULES > 1) ? $clog2(MAX_MODULES) : 1;
  localparam int COUNT_W     = $clog2(MAX_MODULES + 1);
  localparam int ADDR_W      = 64;
  localparam int ROLE_W      = 2;
  localparam int STATUS_W    = 3;
  localparam int POS_W       = 5;
  localparam int CFG_IDX_W   = 1;

  localparam logic [POS_W-1:0] POS_MAX = 5'd31;

  localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
  localparam logic [STATUS_W-1:0] ST_KERNEL_EMPTY = 3'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_MANY     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_ENTRY    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OVERLAP      = 3'd4;
  localparam logic [STATUS_W-1:0] ST_SKIPPED      = 3'd5;

  localparam logic [ROLE_W-1:0] ROLE_INITIAL = 2'd0;
  localparam logic [ROLE_W-1:0] ROLE_AUX     = 2'd1;

  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_BASE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_END  = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic prep;
    logic check;
    logic scan;
    logic commit;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_scan;
    logic scan_hit;
    logic scan_done;
    logic out_free;
  } dp_status_t;

endpackage

// ----- rtl/bmrc_ctrl.sv -----
// Controller state machine of the boot module range checker.
// Sequences capture, precheck, stored-range scan and commit.
// Depends on bmrc_pkg.
module bmrc_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  output bmrc_pkg::ctrl_cmd_t    cmd,
  input  bmrc_pkg::dp_status_t   sts
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PREP   = 3'd1;
  localparam logic [2:0] S_CHECK  = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = sts.need_scan ? S_SCAN : S_FINISH;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_hit || sts.scan_done) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        // The result waits here until the output register is free.
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/bmrc_dp.sv -----
// Datapath of the boot module range checker: configuration, item registers,
// stored range memory, checks and the output register.
// Depends on bmrc_pkg.
module bmrc_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  bmrc_pkg::ctrl_cmd_t                 cmd,
  output bmrc_pkg::dp_status_t                sts,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bmrc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bmrc_pkg::ADDR_W-1:0]         cfg_data,
  input  logic                                in_first_module,
  input  logic                                in_last_module,
  input  logic [bmrc_pkg::ADDR_W-1:0]         in_module_base,
  input  logic [bmrc_pkg::ADDR_W-1:0]         in_module_size,
  input  logic [bmrc_pkg::ROLE_W-1:0]         in_module_role,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [bmrc_pkg::STATUS_W-1:0]       out_status,
  output logic                                out_overlap_with_module,
  output logic [bmrc_pkg::POS_W-1:0]          out_module_index,
  output logic                                out_initial_image,
  output logic                                out_list_valid,
  output logic                                out_list_done
);

  logic [bmrc_pkg::ADDR_W-1:0]   kbase_r;
  logic [bmrc_pkg::ADDR_W-1:0]   kend_r;

  logic                          last_r;
  logic [bmrc_pkg::ADDR_W-1:0]   base_r;
  logic [bmrc_pkg::ADDR_W-1:0]   size_r;
  logic [bmrc_pkg::ROLE_W-1:0]   role_r;
  logic [bmrc_pkg::POS_W-1:0]    index_r;
  logic [bmrc_pkg::ADDR_W-1:0]   end_r;
  logic                          carry_r;

  logic [bmrc_pkg::COUNT_W-1:0]  count_r;
  logic                          failed_r;
  logic [bmrc_pkg::POS_W-1:0]    pos_r;
  logic [bmrc_pkg::POS_W-1:0]    pos_use;

  logic [bmrc_pkg::STATUS_W-1:0] verdict_r;
  logic                          with_mod_r;
  logic [bmrc_pkg::STATUS_W-1:0] pre_status;
  logic                          pre_scan;
  logic                          bad_entry;

  logic [bmrc_pkg::COUNT_W-1:0]  issue_r;
  logic                          cmp_vld_r;
  logic [bmrc_pkg::ADDR_W-1:0]   rd_base_r;
  logic [bmrc_pkg::ADDR_W-1:0]   rd_end_r;

  logic [bmrc_pkg::ADDR_W-1:0]   mem_base [bmrc_pkg::MAX_MODULES];
  logic [bmrc_pkg::ADDR_W-1:0]   mem_end  [bmrc_pkg::MAX_MODULES];

  logic                          out_valid_r;
  logic [bmrc_pkg::STATUS_W-1:0] out_status_r;
  logic                          out_with_mod_r;
  logic [bmrc_pkg::POS_W-1:0]    out_index_r;
  logic                          out_init_r;
  logic                          out_list_valid_r;
  logic                          out_done_r;

  logic                          store_en;
  logic                          issue_more;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kbase_r <= '0;
      kend_r  <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == bmrc_pkg::CFG_KERNEL_BASE) begin
        kbase_r <= cfg_data;
      end else if (cfg_index == bmrc_pkg::CFG_KERNEL_END) begin
        kend_r <= cfg_data;
      end
    end
  end

  assign pos_use = in_first_module ? '0 : pos_r;

  // Item payload and the end address; no reset needed.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      last_r  <= in_last_module;
      base_r  <= in_module_base;
      size_r  <= in_module_size;
      role_r  <= in_module_role;
      index_r <= pos_use;
    end
    if (cmd.prep) begin
      {carry_r, end_r} <= {1'b0, base_r} + {1'b0, size_r};
    end
  end

  assign bad_entry = (base_r == '0) || (size_r == '0) || carry_r ||
                     !(role_r inside {bmrc_pkg::ROLE_INITIAL, bmrc_pkg::ROLE_AUX});

  always_comb begin
    pre_status = bmrc_pkg::ST_OK;
    pre_scan   = 1'b0;
    if (failed_r) begin
      pre_status = bmrc_pkg::ST_SKIPPED;
    end else if (kend_r <= kbase_r) begin
      pre_status = bmrc_pkg::ST_KERNEL_EMPTY;
    end else if (count_r >= bmrc_pkg::COUNT_W'(bmrc_pkg::MAX_MODULES)) begin
      pre_status = bmrc_pkg::ST_TOO_MANY;
    end else if (bad_entry) begin
      pre_status = bmrc_pkg::ST_BAD_ENTRY;
    end else if (base_r < kend_r && kbase_r < end_r) begin
      pre_status = bmrc_pkg::ST_OVERLAP;
    end else begin
      pre_scan = (count_r != '0);
    end
  end

  assign issue_more    = (issue_r < count_r);
  assign sts.need_scan = pre_scan;
  assign sts.scan_hit  = cmp_vld_r && (base_r < rd_end_r) && (rd_base_r < end_r);
  assign sts.scan_done = !cmp_vld_r && !issue_more;
  assign sts.out_free  = !out_valid_r || !out_stall;

  assign store_en = cmd.commit && (verdict_r == bmrc_pkg::ST_OK);

  // List state, verdict and the scan pointer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      failed_r   <= 1'b0;
      pos_r      <= '0;
      verdict_r  <= bmrc_pkg::ST_OK;
      with_mod_r <= 1'b0;
      issue_r    <= '0;
      cmp_vld_r  <= 1'b0;
    end else begin
      if (cmd.capture) begin
        pos_r <= (pos_use == bmrc_pkg::POS_MAX) ? pos_use : pos_use + 1'b1;
        if (in_first_module) begin
          count_r  <= '0;
          failed_r <= 1'b0;
        end
      end
      if (cmd.check) begin
        verdict_r  <= pre_status;
        with_mod_r <= 1'b0;
        issue_r    <= '0;
        cmp_vld_r  <= 1'b0;
      end
      if (cmd.scan) begin
        cmp_vld_r <= issue_more;
        if (issue_more) begin
          issue_r <= issue_r + 1'b1;
        end
        if (sts.scan_hit) begin
          verdict_r  <= bmrc_pkg::ST_OVERLAP;
          with_mod_r <= 1'b1;
        end
      end
      if (cmd.commit) begin
        if (verdict_r == bmrc_pkg::ST_OK) begin
          count_r <= count_r + 1'b1;
        end else begin
          failed_r <= 1'b1;
        end
      end
    end
  end

  // Stored ranges: one write port at commit, one registered read port for the scan.
  always_ff @(posedge clk) begin
    if (store_en) begin
      mem_base[count_r[bmrc_pkg::IDX_W-1:0]] <= base_r;
      mem_end[count_r[bmrc_pkg::IDX_W-1:0]]  <= end_r;
    end
    if (cmd.scan && issue_more) begin
      rd_base_r <= mem_base[issue_r[bmrc_pkg::IDX_W-1:0]];
      rd_end_r  <= mem_end[issue_r[bmrc_pkg::IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status_r     <= verdict_r;
      out_with_mod_r   <= with_mod_r;
      out_index_r      <= index_r;
      out_init_r       <= (role_r == bmrc_pkg::ROLE_INITIAL);
      out_list_valid_r <= (verdict_r == bmrc_pkg::ST_OK);
      out_done_r       <= last_r;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_status              = out_status_r;
  assign out_overlap_with_module = out_with_mod_r;
  assign out_module_index        = out_index_r;
  assign out_initial_image       = out_init_r;
  assign out_list_valid          = out_list_valid_r;
  assign out_list_done           = out_done_r;

endmodule

// ----- rtl/boot_module_range_checker_unit.sv -----
// Boot module range checker, top level.
// Checks one boot module address range per input transaction against the
// kernel range (two configuration registers) and the modules stored so far.
// Input channel in_*: first/last flags, base, size and role of a module.
// Result channel out_*: status, overlap source, position in the list,
// initial-image flag, list verdict so far and a copy of the last flag.
// Configuration channel cfg_*: index 0 kernel base, index 1 kernel end;
// cfg_ready is always high. Write only while no transaction is in flight.
// One module at a time: a transaction runs through capture, precheck, a
// scan of the stored ranges when the precheck passes and any are stored,
// and commit, which loads the result register; only then does the block
// take the next. The scan reads the stored range memory one entry per
// cycle until it finds a hit or has read every stored entry.
// A finished result waits in the output register while out_stall is high;
// the next transaction is accepted meanwhile and holds in its last step
// until the register is taken. Synchronous reset empties the list, clears
// the kernel range and the position counter, and drops out_valid.
// Depends on bmrc_pkg, bmrc_ctrl and bmrc_dp.
module boot_module_range_checker_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bmrc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bmrc_pkg::ADDR_W-1:0]         cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_first_module,
  input  logic                                in_last_module,
  input  logic [bmrc_pkg::ADDR_W-1:0]         in_module_base,
  input  logic [bmrc_pkg::ADDR_W-1:0]         in_module_size,
  input  logic [bmrc_pkg::ROLE_W-1:0]         in_module_role,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [bmrc_pkg::STATUS_W-1:0]       out_status,
  output logic                                out_overlap_with_module,
  output logic [bmrc_pkg::POS_W-1:0]          out_module_index,
  output logic                                out_initial_image,
  output logic                                out_list_valid,
  output logic                                out_list_done
);

  bmrc_pkg::ctrl_cmd_t  cmd;
  bmrc_pkg::dp_status_t sts;

  bmrc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  bmrc_dp u_dp (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cmd                     (cmd),
    .sts                     (sts),
    .cfg_valid               (cfg_valid),
    .cfg_ready               (cfg_ready),
    .cfg_index               (cfg_index),
    .cfg_data                (cfg_data),
    .in_first_module         (in_first_module),
    .in_last_module          (in_last_module),
    .in_module_base          (in_module_base),
    .in_module_size          (in_module_size),
    .in_module_role          (in_module_role),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_status              (out_status),
    .out_overlap_with_module (out_overlap_with_module),
    .out_module_index        (out_module_index),
    .out_initial_image       (out_initial_image),
    .out_list_valid          (out_list_valid),
    .out_list_done           (out_list_done)
  );

  // An accepted transaction keeps the block busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted again straight after an acceptance");

  // Only an overlap with an earlier module sets the module overlap flag.
  a_overlap_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_overlap_with_module) |-> (out_status == bmrc_pkg::ST_OVERLAP))
    else $error("module overlap flag with a status other than overlap");

  // The list verdict follows the status of the result.
  a_list_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_list_valid == (out_status == bmrc_pkg::ST_OK)))
    else $error("list verdict disagrees with the status");

  // The scan never reports a hit and completion together.
  a_scan_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(sts.scan_hit && sts.scan_done))
    else $error("scan hit and scan done at once");

endmodule

// ----- sim/bmrc_verdict_pkg.sv -----
// Scoreboard for the boot module range checker testbench: predicts the verdict
// for every accepted module transaction and checks the results in order.
// Depends on bmrc_pkg for sizes, status codes, role and register indexes.
package bmrc_verdict_pkg;

  import bmrc_pkg::*;

  localparam logic [ADDR_W-1:0] ADDR_TOP         = '1;
  localparam logic [ROLE_W-1:0] ROLE_UNKNOWN_LO  = 2'd2;
  localparam logic [ROLE_W-1:0] ROLE_UNKNOWN_HI  = 2'd3;
  localparam int                MISMATCH_PRINTS  = 40;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                with_module;
    logic [POS_W-1:0]    position;
    logic                initial_image;
    logic                list_valid;
    logic                list_done;
  } verdict_t;

  class range_verdicts;
    logic [ADDR_W-1:0]  kernel_lo;
    logic [ADDR_W-1:0]  kernel_hi;
    logic [ADDR_W-1:0]  range_lo [MAX_MODULES];
    logic [ADDR_W-1:0]  range_hi [MAX_MODULES];
    int                 stored;
    bit                 list_broken;
    logic [POS_W-1:0]   next_position;
    verdict_t           pending [$];
    int                 mismatches;

    function new();
      kernel_lo     = '0;
      kernel_hi     = '0;
      stored        = 0;
      list_broken   = 1'b0;
      next_position = '0;
      mismatches    = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] index, logic [ADDR_W-1:0] data);
      if (index == CFG_KERNEL_BASE) begin
        kernel_lo = data;
      end else if (index == CFG_KERNEL_END) begin
        kernel_hi = data;
      end
    endfunction

    // Works out the verdict for one module and updates the stored list.
    function void note_module(bit first, bit last, logic [ADDR_W-1:0] base,
                              logic [ADDR_W-1:0] size, logic [ROLE_W-1:0] role);
      verdict_t          v;
      logic [ADDR_W-1:0] top;
      int                k;
      if (first) begin
        stored        = 0;
        list_broken   = 1'b0;
        next_position = '0;
      end
      v.position = next_position;
      if (next_position < POS_MAX) begin
        next_position = next_position + 1'b1;
      end
      v.status      = ST_OK;
      v.with_module = 1'b0;
      if (list_broken) begin
        v.status = ST_SKIPPED;
      end else if (kernel_hi <= kernel_lo) begin
        v.status = ST_KERNEL_EMPTY;
      end else if (stored >= MAX_MODULES) begin
        v.status = ST_TOO_MANY;
      end else if (base == '0 || size == '0 || base > ~size || role > ROLE_AUX) begin
        v.status = ST_BAD_ENTRY;
      end else begin
        top = base + size;
        // Ranges are half open, so touching ranges pass.
        if (base < kernel_hi && kernel_lo < top) begin
          v.status = ST_OVERLAP;
        end else begin
          for (k = 0; k < stored; k++) begin
            if (base < range_hi[k] && range_lo[k] < top) begin
              v.status      = ST_OVERLAP;
              v.with_module = 1'b1;
              break;
            end
          end
        end
        if (v.status == ST_OK) begin
          range_lo[stored] = base;
          range_hi[stored] = top;
          stored++;
        end
      end
      if (v.status != ST_OK) begin
        list_broken = 1'b1;
      end
      v.initial_image = (role == ROLE_INITIAL);
      v.list_valid    = !list_broken;
      v.list_done     = last;
      pending.push_back(v);
    endfunction

    task report_mismatch(string what);
      mismatches++;
      if (mismatches <= MISMATCH_PRINTS) begin
        $display("MISMATCH at %0t: %s", $realtime, what);
      end
    endtask

    task check_verdict(verdict_t got);
      verdict_t want;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("result with no transaction outstanding: %p", got));
      end else begin
        want = pending.pop_front();
        if (got.status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d (position %0d)",
                                    got.status, want.status, want.position));
        if (got.with_module !== want.with_module)
          report_mismatch($sformatf("overlap_with_module got %0b want %0b (position %0d)",
                                    got.with_module, want.with_module, want.position));
        if (got.position !== want.position)
          report_mismatch($sformatf("module_index got %0d want %0d",
                                    got.position, want.position));
        if (got.initial_image !== want.initial_image)
          report_mismatch($sformatf("initial_image got %0b want %0b (position %0d)",
                                    got.initial_image, want.initial_image, want.position));
        if (got.list_valid !== want.list_valid)
          report_mismatch($sformatf("list_valid got %0b want %0b (position %0d)",
                                    got.list_valid, want.list_valid, want.position));
        if (got.list_done !== want.list_done)
          report_mismatch($sformatf("list_done got %0b want %0b (position %0d)",
                                    got.list_done, want.list_done, want.position));
      end
    endtask
  endclass

endpackage

// ----- sim/boot_module_range_checker_unit_tb.sv -----
// Top-level testbench for boot_module_range_checker_unit: directed module lists,
// then random lists under several kernel ranges, with random stalls on both sides.
// Depends on bmrc_pkg, bmrc_verdict_pkg and the RTL of the block.
module boot_module_range_checker_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bmrc_pkg::*;
  import bmrc_verdict_pkg::*;

  localparam int QUIET_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 90;
  localparam int HOLD_AT      = 250;
  localparam int CALM_FROM    = 700;
  localparam int CALM_TO      = 900;

  logic                 clk;
  logic                 rst_n                   = 1'b0;
  logic                 cfg_valid               = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index               = CFG_KERNEL_BASE;
  logic [ADDR_W-1:0]    cfg_data                = '0;
  logic                 in_valid                = 1'b0;
  logic                 in_stall;
  logic                 in_first_module         = 1'b0;
  logic                 in_last_module          = 1'b0;
  logic [ADDR_W-1:0]    in_module_base          = '0;
  logic [ADDR_W-1:0]    in_module_size          = '0;
  logic [ROLE_W-1:0]    in_module_role          = ROLE_INITIAL;
  logic                 out_valid;
  logic                 out_stall               = 1'b1;
  logic [STATUS_W-1:0]  out_status;
  logic                 out_overlap_with_module;
  logic [POS_W-1:0]     out_module_index;
  logic                 out_initial_image;
  logic                 out_list_valid;
  logic                 out_list_done;

  range_verdicts verdicts = new();

  int sent_modules  = 0;
  int quiet_cycles  = 0;
  int hold_left     = 0;
  bit calm          = 1'b0;
  bit hold_request  = 1'b0;
  bit hold_taken    = 1'b0;

  boot_module_range_checker_unit DUT (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver: random stalls, plus one long hold-off so that the block backs up.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_request && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      out_stall  <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < 11);
    end
  end

  // Observes every transaction on the three channels and keeps the watchdog.
  always @(posedge clk) begin : observe
    verdict_t got;
    bit       moved;
    moved = 1'b0;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        verdicts.write_register(cfg_index, cfg_data);
        moved = 1'b1;
      end
      if (in_valid && !in_stall) begin
        verdicts.note_module(in_first_module, in_last_module, in_module_base,
                             in_module_size, in_module_role);
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        got.status        = out_status;
        got.with_module   = out_overlap_with_module;
        got.position      = out_module_index;
        got.initial_image = out_initial_image;
        got.list_valid    = out_list_valid;
        got.list_done     = out_list_done;
        verdicts.check_verdict(got);
        moved = 1'b1;
      end
      if (moved) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb: failure");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic logic [ADDR_W-1:0] any_address();
    return {$urandom, $urandom};
  endfunction

  task automatic send_module(bit first, bit last, logic [ADDR_W-1:0] base,
                             logic [ADDR_W-1:0] size, logic [ROLE_W-1:0] role);
    while (!calm && $urandom_range(0, 99) < 11) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_first_module <= first;
    in_last_module  <= last;
    in_module_base  <= base;
    in_module_size  <= size;
    in_module_role  <= role;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_modules++;
    calm = (sent_modules >= CALM_FROM && sent_modules < CALM_TO);
    if (sent_modules == HOLD_AT) hold_request = 1'b1;
  endtask

  // Waits until every verdict has come back, with the input channel quiet.
  task automatic drain(int settle);
    in_valid <= 1'b0;
    while (verdicts.pending.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_kernel(logic [ADDR_W-1:0] lo, logic [ADDR_W-1:0] hi);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_KERNEL_BASE;
    cfg_data  <= lo;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= CFG_KERNEL_END;
    cfg_data  <= hi;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One list of modules: mostly well-formed ranges laid out upwards from a
  // starting point, with some overlaps, malformed entries and noise mixed in.
  task automatic send_list(int count);
    logic [ADDR_W-1:0] cursor;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] size;
    logic [ADDR_W-1:0] prev_base;
    logic [ROLE_W-1:0] role;
    bit                first;
    bit                last;
    bit                headless;
    int                pick;
    int                i;
    headless = ($urandom_range(0, 99) < 5);
    case ($urandom_range(0, 3))
      0:       cursor = verdicts.kernel_hi;
      1:       cursor = any_address();
      2:       cursor = ADDR_W'($urandom_range(1, 65535));
      default: cursor = verdicts.kernel_lo - $urandom_range(1, 4096);
    endcase
    prev_base = cursor;
    for (i = 0; i < count; i++) begin
      first = (i == 0) && !headless;
      last  = (i == count - 1);
      role  = ROLE_W'($urandom_range(0, 1));
      pick  = $urandom_range(0, 99);
      if (pick < 84) begin
        case ($urandom_range(0, 2))
          0:       base = cursor;
          1:       base = cursor + $urandom_range(1, 255);
          default: base = cursor + $urandom;
        endcase
        case ($urandom_range(0, 3))
          0:       size = ADDR_W'(1);
          1:       size = ADDR_W'($urandom_range(2, 4096));
          2:       size = ADDR_W'($urandom);
          default: size = {$urandom_range(0, 255), $urandom};
        endcase
        cursor = base + size;
      end else if (pick < 90) begin
        base = prev_base;
        size = ADDR_W'($urandom_range(1, 64));
      end else if (pick < 96) begin
        base = cursor + 1;
        size = ADDR_W'(1);
        case ($urandom_range(0, 3))
          0: base = '0;
          1: size = '0;
          2: begin
            // Top bit set keeps the complement below 2^63, so this always overflows.
            base = any_address() | {1'b1, {(ADDR_W-1){1'b0}}};
            size = ~base + $urandom_range(1, 16);
          end
          default: role = ROLE_W'($urandom_range(ROLE_UNKNOWN_LO, ROLE_UNKNOWN_HI));
        endcase
      end else begin
        first = 1'($urandom_range(0, 1));
        last  = 1'($urandom_range(0, 1));
        base  = any_address();
        size  = any_address();
        role  = ROLE_W'($urandom_range(0, 3));
      end
      prev_base = base;
      send_module(first, last, base, size, role);
    end
  endtask

  task automatic run_phase(logic [ADDR_W-1:0] lo, logic [ADDR_W-1:0] hi, int budget);
    int count;
    int pick;
    drain(4);
    write_kernel(lo, hi);
    while (budget > 0) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) count = $urandom_range(1, 12);
      else if (pick < 92) count = $urandom_range(13, 20);
      else count = 34;
      send_list(count);
      budget -= count;
    end
  endtask

  initial begin : stimulus
    logic [ADDR_W-1:0] lo;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Kernel range still empty from reset; the first item precedes any list start.
    send_module(1'b0, 1'b0, 64'h1, 64'h1, ROLE_INITIAL);
    send_module(1'b0, 1'b1, 64'h10, 64'h10, ROLE_AUX);
    send_module(1'b1, 1'b1, 64'h10, 64'h10, ROLE_AUX);
    drain(4);
    write_kernel(64'h1000, 64'h2000);

    // Touching ranges, the highest possible end, then an overlap with a module.
    send_module(1'b1, 1'b0, 64'h2000, 64'h1000, ROLE_INITIAL);
    send_module(1'b0, 1'b0, 64'h0FFF, 64'h1, ROLE_AUX);
    send_module(1'b0, 1'b0, 64'h3000, 64'h10, ROLE_INITIAL);
    send_module(1'b0, 1'b0, ADDR_TOP - 16, 64'd16, ROLE_AUX);
    send_module(1'b0, 1'b1, 64'h3008, 64'h4, ROLE_INITIAL);
    // Carries on past the last flag without a new start; the list has already failed, so it is skipped.
    send_module(1'b0, 1'b0, 64'h5000, 64'h1, ROLE_INITIAL);
    send_module(1'b1, 1'b1, 64'h0, 64'h10, ROLE_INITIAL);
    send_module(1'b1, 1'b1, 64'h4000, 64'h0, ROLE_AUX);
    send_module(1'b1, 1'b0, 64'h1, ADDR_TOP, ROLE_INITIAL);
    send_module(1'b0, 1'b1, 64'h4000, 64'h1, ROLE_AUX);
    send_module(1'b1, 1'b1, ADDR_TOP - 15, 64'd16, ROLE_INITIAL);
    send_module(1'b1, 1'b1, ADDR_TOP, 64'h1, ROLE_AUX);
    send_module(1'b1, 1'b1, 64'h4000, 64'h1, ROLE_UNKNOWN_LO);
    send_module(1'b1, 1'b1, 64'h4000, 64'h1, ROLE_UNKNOWN_HI);
    send_module(1'b1, 1'b1, 64'h1FFF, 64'h1, ROLE_AUX);
    send_module(1'b1, 1'b1, 64'h0800, 64'h1000, ROLE_INITIAL);

    run_phase(64'h1000_0000, 64'h2000_0000, 400);
    lo = any_address();
    run_phase(lo, lo + $urandom, 250);
    run_phase(64'h0, 64'h1, 250);
    run_phase(ADDR_TOP - 1, ADDR_TOP, 200);
    run_phase(64'h0, ADDR_TOP, 60);
    run_phase(ADDR_TOP, 64'h0, 40);
    lo = ADDR_W'($urandom);
    run_phase(lo, lo + $urandom_range(1, 32'hFFFF_FFFF), 300);

    drain(MAX_MODULES + 8);
    if (verdicts.mismatches == 0 && verdicts.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
